[rtl/running_average_filter_defines.svh]
// Assertion macros for the running average filter
`ifndef RUNNING_AVERAGE_FILTER_DEFINES_SVH
`define RUNNING_AVERAGE_FILTER_DEFINES_SVH

// same-cycle implication
`define RAF_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("running_average_filter: assertion failed");

// next-cycle implication
`define RAF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("running_average_filter: assertion failed");

`endif

[rtl/raf_pkg.sv]
`timescale 1ns / 1ps
package raf_pkg;

    localparam int WindowMaxDefault  = 64;
    localparam int SampleBitsDefault = 16;
    localparam int CountBits         = 7;
    localparam logic [CountBits-1:0] WindowReset = 7'd64;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_FETCH  = 3'b010,
        ST_DIVIDE = 3'b100
    } state_t;

    typedef struct packed {
        logic capture;
        logic update;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } ctrl_status_t;

endpackage

[rtl/running_average_filter.sv]
// A sample is captured in IDLE, the store is updated and the divider started in FETCH,
// and the result is loaded in DIVIDE once the divider is done and the output is free;
// a new sample is taken only back in IDLE. The radix-2 divider gives one quotient bit per cycle.
// Reset clears sum, write position and fill count and loads a window of 64; unwritten
// store entries are masked by the fill count, so there is no clearing pass.
// A window_size write clears sum, position and count in the same way.
`timescale 1ns / 1ps
`include "running_average_filter_defines.svh"
module running_average_filter
    import raf_pkg::*;
#(
    parameter int WINDOW_MAX  = WindowMaxDefault,
    parameter int SAMPLE_BITS = SampleBitsDefault
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CountBits-1:0]          window_size,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0] average,
    output logic [CountBits-1:0]          samples_held
);

    ctrl_cmd_t    cmd;
    ctrl_status_t status;

    assign cfg_ready = 1'b1;

    raf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    raf_datapath #(
        .WINDOW_MAX  (WINDOW_MAX),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .sample       (sample),
        .cfg_we       (cfg_valid && cfg_ready),
        .window_size  (window_size),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .average      (average),
        .samples_held (samples_held)
    );

    `RAF_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)
    `RAF_ASSERT_IMPLY(a_held_nonzero, clk, rst_n, out_valid, samples_held != '0)
    `RAF_ASSERT_IMPLY(a_result_from_busy, clk, rst_n, $rose(out_valid), !$past(in_ready))

endmodule

[rtl/raf_ram.sv]
`timescale 1ns / 1ps
module raf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/raf_div.sv]
`timescale 1ns / 1ps
module raf_div #(
    parameter int NUM_BITS = 22,
    parameter int DEN_BITS = 7
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic signed [NUM_BITS-1:0] numer,
    input  logic [DEN_BITS-1:0]        denom,
    output logic                       done,
    output logic signed [NUM_BITS-1:0] quotient
);

    localparam int StepBits = $clog2(NUM_BITS + 1);

    logic [NUM_BITS-1:0] quo_reg;
    logic [DEN_BITS-1:0] rem_reg;
    logic [DEN_BITS-1:0] den_reg;
    logic                neg_reg;
    logic [StepBits-1:0] step_reg;
    logic                busy_reg;
    logic                done_reg;
    logic [DEN_BITS:0]   trial;
    logic [DEN_BITS:0]   diff;
    logic                fits;

    assign trial = {rem_reg, quo_reg[NUM_BITS-1]};
    assign fits  = trial >= {1'b0, den_reg};
    assign diff  = trial - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= StepBits'(NUM_BITS);
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg - 1'b1;
            if (step_reg == StepBits'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= numer[NUM_BITS-1] ? NUM_BITS'(-numer) : NUM_BITS'(numer);
            rem_reg <= '0;
            den_reg <= denom;
            neg_reg <= numer[NUM_BITS-1];
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
            quo_reg <= {quo_reg[NUM_BITS-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? -signed'(quo_reg) : signed'(quo_reg);

endmodule

[rtl/raf_datapath.sv]
`timescale 1ns / 1ps
module raf_datapath
    import raf_pkg::*;
#(
    parameter int WINDOW_MAX  = WindowMaxDefault,
    parameter int SAMPLE_BITS = SampleBitsDefault
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ctrl_cmd_t                     cmd,
    output ctrl_status_t                  status,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic                          cfg_we,
    input  logic [CountBits-1:0]          window_size,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0] average,
    output logic [CountBits-1:0]          samples_held
);

    localparam int PosBits = $clog2(WINDOW_MAX);
    localparam int SumBits = SAMPLE_BITS + $clog2(WINDOW_MAX);

    logic [CountBits-1:0]          window_reg;
    logic signed [SumBits-1:0]     sum_reg;
    logic signed [SumBits-1:0]     sum_next;
    logic [PosBits-1:0]            pos_reg;
    logic [PosBits-1:0]            pos_next;
    logic [CountBits-1:0]          count_reg;
    logic [CountBits-1:0]          count_next;
    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic signed [SAMPLE_BITS-1:0] old_sample;
    logic [SAMPLE_BITS-1:0]        rd_data;
    logic [CountBits-1:0]          eff_window;
    logic                          out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] average_reg;
    logic [CountBits-1:0]          held_reg;
    logic                          div_done;
    logic signed [SumBits-1:0]     quotient;

    always_comb
    begin
        if (window_reg == '0)
        begin
            eff_window = CountBits'(1);
        end
        else if (int'(window_reg) > WINDOW_MAX)
        begin
            eff_window = CountBits'(WINDOW_MAX);
        end
        else
        begin
            eff_window = window_reg;
        end
    end

    // entries at or beyond the fill count have not been written since the clear
    assign old_sample = (count_reg < eff_window) ? '0 : signed'(rd_data);
    assign sum_next   = sum_reg - SumBits'(old_sample) + SumBits'(sample_reg);
    assign pos_next   = (int'(pos_reg) + 1 >= int'(eff_window)) ? '0 : pos_reg + 1'b1;
    assign count_next = (count_reg < eff_window) ? count_reg + 1'b1 : count_reg;

    raf_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (WINDOW_MAX)
    ) u_store (
        .clk   (clk),
        .we    (cmd.update),
        .waddr (pos_reg),
        .wdata (sample_reg),
        .re    (cmd.capture),
        .raddr (pos_reg),
        .rdata (rd_data)
    );

    raf_div #(
        .NUM_BITS (SumBits),
        .DEN_BITS (CountBits)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.update),
        .numer    (sum_next),
        .denom    (count_next),
        .done     (div_done),
        .quotient (quotient)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg    <= WindowReset;
            sum_reg       <= '0;
            pos_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                window_reg <= window_size;
                sum_reg    <= '0;
                pos_reg    <= '0;
                count_reg  <= '0;
            end
            else if (cmd.update)
            begin
                sum_reg   <= sum_next;
                pos_reg   <= pos_next;
                count_reg <= count_next;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            sample_reg <= sample;
        end
        if (cmd.load_out)
        begin
            average_reg <= quotient[SAMPLE_BITS-1:0];
            held_reg    <= count_reg;
        end
    end

    assign status.div_done = div_done;
    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign average         = average_reg;
    assign samples_held    = held_reg;

endmodule

[rtl/raf_ctrl.sv]
`timescale 1ns / 1ps
module raf_ctrl
    import raf_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  ctrl_status_t status,
    output ctrl_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                cmd.update = 1'b1;
                state_next = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                if (status.div_done && status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

endmodule

[tb/running_average_filter_tb.sv]
`timescale 1ns / 1ps
module running_average_filter_tb;
    import raf_pkg::*;

    localparam int SampleBits  = SampleBitsDefault;
    localparam int WindowMax   = WindowMaxDefault;
    localparam int CycleLimit  = 500000;
    localparam int DrainCycles = 40;
    localparam int PhaseItems  = 150;
    localparam int LongHold    = 300;

    typedef struct {
        logic signed [SampleBits-1:0] average;
        logic [CountBits-1:0]         held;
    } average_result_t;

    class average_tracker;
        logic signed [SampleBits-1:0] history [WindowMax];
        int                           sum;
        int                           position;
        int                           fill;
        logic [CountBits-1:0]         window_reg;
        average_result_t              pending_averages [$];
        int                           errors;

        function new();
            window_reg = WindowReset;
            errors     = 0;
            clear();
        endfunction

        function void clear();
            foreach (history[i])
                history[i] = '0;
            sum      = 0;
            position = 0;
            fill     = 0;
        endfunction

        function void set_window(logic [CountBits-1:0] value);
            window_reg = value;
            clear();
        endfunction

        function void note_sample(logic signed [SampleBits-1:0] value);
            int              size;
            average_result_t r;
            if (window_reg == 0)
                size = 1;
            else if (window_reg > WindowMax)
                size = WindowMax;
            else
                size = window_reg;
            if (position >= size)
                position = 0;
            sum = sum - history[position] + value;
            history[position] = value;
            position++;
            if (position >= size)
                position = 0;
            if (fill < size)
                fill++;
            r.average = SampleBits'(sum / fill);
            r.held    = CountBits'(fill);
            pending_averages.push_back(r);
        endfunction

        function void check_average(logic signed [SampleBits-1:0] average,
                                    logic [CountBits-1:0] held);
            average_result_t r;
            if (pending_averages.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result: average %0d samples_held %0d",
                         $time, average, held);
                return;
            end
            r = pending_averages.pop_front();
            if (average !== r.average)
            begin
                errors++;
                $display("%0t: average mismatch: expected %0d actual %0d",
                         $time, r.average, average);
            end
            if (held !== r.held)
            begin
                errors++;
                $display("%0t: samples_held mismatch: expected %0d actual %0d",
                         $time, r.held, held);
            end
        endfunction

        function int pending();
            return pending_averages.size();
        endfunction
    endclass

    logic                         clk = 1'b0;
    logic                         rst_n;
    logic                         cfg_valid;
    logic                         cfg_ready;
    logic [CountBits-1:0]         window_size;
    logic                         in_valid;
    logic                         in_ready;
    logic signed [SampleBits-1:0] sample;
    logic                         out_valid;
    logic                         out_ready;
    logic signed [SampleBits-1:0] average;
    logic [CountBits-1:0]         samples_held;

    average_tracker tracker;
    bit             tx_idling;
    bit             rx_idling;
    int             rx_hold;

    running_average_filter u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .window_size  (window_size),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .sample       (sample),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .average      (average),
        .samples_held (samples_held)
    );

    always #1 clk = ~clk;

    // receiver: a long hold, when set, takes priority; otherwise random stall bursts while rx_idling
    initial
    begin
        int stall_left;
        stall_left = 0;
        out_ready  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold > 0)
            begin
                out_ready <= 1'b0;
                rx_hold--;
            end
            else if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else if (rx_idling && $urandom_range(0, 4) == 0)
            begin
                out_ready  <= 1'b0;
                stall_left = $urandom_range(1, 3) - 1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                tracker.check_average(average, samples_held);
            if (cfg_valid && cfg_ready)
                tracker.set_window(window_size);
            if (in_valid && in_ready)
                tracker.note_sample(sample);
        end
    end

    initial
    begin
        repeat (CycleLimit) @(posedge clk);
        $display("TB_ERROR");
        $finish;
    end

    task automatic send_sample(input logic signed [SampleBits-1:0] value);
        int gap;
        gap = (tx_idling && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        sample   <= value;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_window(input logic [CountBits-1:0] value);
        drain();
        cfg_valid   <= 1'b1;
        window_size <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_random(input int count);
        logic signed [SampleBits-1:0] v;
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(0, 9))
                0: v = 16'sh7FFF;
                1: v = 16'sh8000;
                2: v = SampleBits'($urandom_range(0, 16) - 8);
                3: v = 16'sh7FFF - SampleBits'($urandom_range(0, 3));
                4: v = 16'sh8000 + SampleBits'($urandom_range(0, 3));
                default: v = SampleBits'($urandom);
            endcase
            send_sample(v);
        end
    endtask

    initial
    begin
        logic signed [SampleBits-1:0] at_reset [] = '{16'sh7FFF, 16'sh7FFF, 16'sh8000,
            16'sh8000, 16'sh0000, -16'sd1, 16'sd1, -16'sd1, 16'sh7FFF, 16'sh8000,
            16'sd12345, -16'sd12345, 16'sd3};
        logic signed [SampleBits-1:0] at_two [] = '{16'sh8000, -16'sd32767,
            16'sh7FFF, 16'sd32766, -16'sd3};

        tracker     = new();
        tx_idling   = 1'b1;
        rx_idling   = 1'b1;
        rx_hold     = 0;
        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        window_size = '0;
        in_valid    = 1'b0;
        sample      = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (at_reset[i])
            send_sample(at_reset[i]);
        write_window(7'd1);
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        send_sample(-16'sd1);
        write_window(7'd0);
        send_sample(16'sh8000);
        send_sample(16'sd5);
        write_window(7'd2);
        foreach (at_two[i])
            send_sample(at_two[i]);

        write_window(7'd127);
        send_random(PhaseItems);
        write_window(7'd65);
        send_random(PhaseItems);
        write_window(7'd64);
        send_random(PhaseItems);

        // output held off while the sender keeps offering
        write_window(7'd3);
        @(posedge clk);
        rx_hold = LongHold;
        @(negedge clk);
        send_random(PhaseItems);

        write_window(7'd7);
        send_random(PhaseItems / 2);
        drain();
        send_random(PhaseItems / 2);

        write_window(7'd2);
        send_random(PhaseItems);
        for (int p = 0; p < 4; p++)
        begin
            write_window(CountBits'($urandom_range(0, 127)));
            send_random(PhaseItems);
        end

        write_window(7'd64);
        tx_idling = 1'b0;
        rx_idling = 1'b0;
        send_random(PhaseItems);
        write_window(CountBits'($urandom_range(1, 64)));
        send_random(PhaseItems);

        drain();
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/raf_pkg.sv
rtl/raf_ram.sv
rtl/raf_div.sv
rtl/raf_datapath.sv
rtl/raf_ctrl.sv
rtl/running_average_filter.sv
tb/running_average_filter_tb.sv
